// ===== src/tlvd_pkg.sv =====
package tlvd_pkg;

	localparam int QUEUE_AW = 2;

	localparam logic [1:0] KIND_PKT_HDR = 2'd0;
	localparam logic [1:0] KIND_TLV_HDR = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;

	localparam logic [15:0] TYPE_IFRAME = 16'h0064;
	localparam logic [15:0] TYPE_PFRAME = 16'h0066;

	localparam int TDATA_W = 64;
	localparam int TUSER_W = 4;

	typedef enum logic [2:0] {
		PH_PKT = 3'b001,
		PH_TLV = 3'b010,
		PH_PAY = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [1:0]  byte_kind;
		logic [15:0] tlv_code;
		logic        to_handler;
		logic        tlv_end;
		logic        packet_end;
		logic [31:0] seq_no;
		logic        frame_error;
	} result_t;

endpackage

// ===== src/tlvd_front.sv =====
module tlvd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              q_full,
	output logic              push,
	output tlvd_pkg::result_t push_data
);
	import tlvd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  hidx_q, hidx_d;
	logic [31:0] pleft_q, pleft_d;
	logic [31:0] seq_q, seq_d;
	logic [15:0] ctype_q, ctype_d;
	logic [15:0] payl_q, payl_d;
	result_t     res;

	assign in_ready  = !q_full;
	assign push      = in_valid && !q_full;
	assign push_data = res;

	always_comb begin
		phase_d = phase_q;
		hidx_d  = hidx_q;
		pleft_d = pleft_q;
		seq_d   = seq_q;
		ctype_d = ctype_q;
		payl_d  = payl_q;
		res            = '0;
		res.byte_value = in_byte;
		unique case (phase_q)
			PH_TLV: begin
				res.byte_kind = KIND_TLV_HDR;
				unique case (hidx_q[1:0])
					2'd0: ctype_d = {8'b0, in_byte};
					2'd1: ctype_d = {in_byte, ctype_q[7:0]};
					2'd2: payl_d  = {8'b0, in_byte};
					default: payl_d = {in_byte, payl_q[7:0]};
				endcase
				if (hidx_q[1:0] != 2'd3) begin
					hidx_d = {1'b0, hidx_q[1:0] + 2'd1};
				end else if (({16'b0, payl_d} + 32'd4) > pleft_q) begin
					res.frame_error = 1'b1;
					phase_d = PH_PKT;
					hidx_d  = 3'd0;
				end else begin
					pleft_d = pleft_q - 32'd4;
					hidx_d  = 3'd0;
					if (payl_d == 16'd0) begin
						res.tlv_end = 1'b1;
						if (pleft_d == 32'd0) begin
							phase_d = PH_PKT;
							res.packet_end = 1'b1;
						end else begin
							phase_d = PH_TLV;
						end
					end else begin
						phase_d = PH_PAY;
					end
				end
			end
			PH_PAY: begin
				res.byte_kind  = KIND_PAYLOAD;
				res.tlv_code   = ctype_q;
				res.to_handler = (ctype_q == TYPE_IFRAME) || (ctype_q == TYPE_PFRAME);
				if (payl_q != 16'd0) payl_d = payl_q - 16'd1;
				if (pleft_q != 32'd0) pleft_d = pleft_q - 32'd1;
				if (payl_d == 16'd0) begin
					res.tlv_end = 1'b1;
					hidx_d = 3'd0;
					if (pleft_d == 32'd0) begin
						phase_d = PH_PKT;
						res.packet_end = 1'b1;
					end else begin
						phase_d = PH_TLV;
					end
				end
			end
			default: begin
				res.byte_kind = KIND_PKT_HDR;
				phase_d = PH_PKT;
				unique case (hidx_q)
					3'd0:             pleft_d = {24'b0, in_byte};
					3'd1, 3'd2, 3'd3: pleft_d = {pleft_q[23:0], in_byte};
					3'd4:             seq_d   = {24'b0, in_byte};
					3'd5:             seq_d   = seq_q | {16'b0, in_byte, 8'b0};
					3'd6:             seq_d   = seq_q | {8'b0, in_byte, 16'b0};
					default:          seq_d   = seq_q | {in_byte, 24'b0};
				endcase
				if (hidx_q != 3'd7) begin
					hidx_d = hidx_q + 3'd1;
				end else begin
					hidx_d = 3'd0;
					if (pleft_q <= 32'd4) begin
						res.frame_error = 1'b1;
						pleft_d = 32'd0;
					end else begin
						pleft_d = pleft_q - 32'd4;
						phase_d = PH_TLV;
					end
				end
			end
		endcase
		res.seq_no = seq_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PKT;
			hidx_q  <= 3'd0;
			pleft_q <= 32'd0;
			seq_q   <= 32'd0;
			ctype_q <= 16'd0;
			payl_q  <= 16'd0;
		end else if (push) begin
			phase_q <= phase_d;
			hidx_q  <= hidx_d;
			pleft_q <= pleft_d;
			seq_q   <= seq_d;
			ctype_q <= ctype_d;
			payl_q  <= payl_d;
		end
	end

endmodule

// ===== src/tlvd_queue.sv =====
module tlvd_queue #(
	parameter int Aw = tlvd_pkg::QUEUE_AW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tlvd_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output tlvd_pkg::result_t out_data
);
	import tlvd_pkg::*;

	localparam int Depth = 1 << Aw;

	result_t         mem_q [Depth];
	logic [Aw-1:0]   wr_q, rd_q;
	logic [Aw:0]     count_q;
	logic            pop;

	assign full      = (count_q == (Aw+1)'(Depth));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + Aw'(1);
			if (pop)  rd_q <= rd_q + Aw'(1);
			if (push && !pop)      count_q <= count_q + (Aw+1)'(1);
			else if (pop && !push) count_q <= count_q - (Aw+1)'(1);
		end
	end

endmodule

// ===== src/tlv_packet_deframer.sv =====
// Length-prefixed TLV deframer for a received byte stream.
// Slave stream: one byte per transaction in s_axis_tdata[7:0].
// Master stream: one tagged byte per transaction. tlast marks the last byte
// of a packet; tuser carries the byte kind (packet header, TLV header,
// payload), the forward flag for I-frame and P-frame payload, and the
// frame error flag. tdata carries the byte, TLV type, TLV end mark and
// the packet sequence number.
// The parser classifies each byte in the cycle it is taken and writes the
// result into a small queue (2**QueueAw entries); the result is registered
// there before it is offered on the master side. One byte per cycle is
// sustained as long as the master side takes a transaction every cycle.
// When the receiver stalls, the queue fills and s_axis_tready drops once it
// is full; nothing is dropped.
// After reset the parser waits for the first byte of a packet header and
// the queue is empty. A bad length raises frame_error and the parser
// resynchronizes on the next byte as a packet header.
module tlv_packet_deframer #(
	parameter int QueueAw = tlvd_pkg::QUEUE_AW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // in_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// byte_value[7:0], tlv_code[23:8], tlv_end[24], seq_no[56:25], zero pad
	output logic [tlvd_pkg::TDATA_W-1:0]  m_axis_tdata,
	// byte_kind[1:0], to_handler[2], frame_error[3]
	output logic [tlvd_pkg::TUSER_W-1:0]  m_axis_tuser,
	output logic                          m_axis_tlast   // packet_end
);
	import tlvd_pkg::*;

	logic    q_full;
	logic    push;
	result_t push_data;
	result_t out_data;

	tlvd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	tlvd_queue #(
		.Aw (QueueAw)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	assign m_axis_tdata = {7'b0, out_data.seq_no, out_data.tlv_end,
		out_data.tlv_code, out_data.byte_value};
	assign m_axis_tuser = {out_data.frame_error, out_data.to_handler, out_data.byte_kind};
	assign m_axis_tlast = out_data.packet_end;

endmodule

// ===== sim/tlv_packet_deframer_test.sv =====
`timescale 1ns / 100ps

module tlv_packet_deframer_test;
	import tlvd_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_BYTES = 1400;
	localparam int HOLD_CYCLES = 60;
	localparam int DIR_COUNT = 24;

	typedef struct packed {
		logic [7:0] din;
		logic       typed;
		result_t    tag;
	} dir_row_t;

	localparam result_t NO_TAG = '0;

	// typed rows: first byte after reset, short packet error, zero-length TLV end,
	// TLV overrun error
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		'{8'h00, 1'b1, '{8'h00, KIND_PKT_HDR, 16'h0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0}},
		'{8'h00, 1'b0, NO_TAG},
		'{8'h00, 1'b0, NO_TAG},
		'{8'h04, 1'b0, NO_TAG},
		'{8'h01, 1'b0, NO_TAG},
		'{8'hFF, 1'b0, NO_TAG},
		'{8'h00, 1'b0, NO_TAG},
		'{8'h80, 1'b1, '{8'h80, KIND_PKT_HDR, 16'h0, 1'b0, 1'b0, 1'b0, 32'h8000FF01, 1'b1}},
		'{8'h00, 1'b0, NO_TAG},
		'{8'h00, 1'b0, NO_TAG},
		'{8'h00, 1'b0, NO_TAG},
		'{8'h0A, 1'b0, NO_TAG},
		'{8'h44, 1'b0, NO_TAG},
		'{8'h33, 1'b0, NO_TAG},
		'{8'h22, 1'b0, NO_TAG},
		'{8'h11, 1'b0, NO_TAG},
		'{8'h64, 1'b0, NO_TAG},
		'{8'h00, 1'b0, NO_TAG},
		'{8'h00, 1'b0, NO_TAG},
		'{8'h00, 1'b1, '{8'h00, KIND_TLV_HDR, 16'h0, 1'b0, 1'b1, 1'b0, 32'h11223344, 1'b0}},
		'{8'h66, 1'b0, NO_TAG},
		'{8'h00, 1'b0, NO_TAG},
		'{8'hFF, 1'b0, NO_TAG},
		'{8'hFF, 1'b1, '{8'hFF, KIND_TLV_HDR, 16'h0, 1'b0, 1'b0, 1'b0, 32'h11223344, 1'b1}}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic [TUSER_W-1:0]   m_axis_tuser;
	logic                 m_axis_tlast;

	// predicted parser state
	phase_t      ph;
	logic [2:0]  hdr_idx;
	logic [32:0] pkt_left;
	logic [31:0] seq;
	logic [15:0] cur_type;
	logic [15:0] pay_left;

	result_t expected_tags [$];
	int      mismatch_count = 0;
	int      bytes_sent = 0;
	int      stall_cycles = 0;
	bit      idle_on = 1'b1;
	bit      hold_req = 1'b0;

	tlv_packet_deframer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic end_of_tlv();
		hdr_idx = 3'd0;
		if (pkt_left == 33'd0) begin
			ph = PH_PKT;
			return 1'b1;
		end
		ph = PH_TLV;
		return 1'b0;
	endfunction

	function automatic result_t deframe_byte(input logic [7:0] b);
		result_t r;
		logic [2:0] idx;
		r = '0;
		r.byte_value = b;
		case (ph)
			PH_TLV: begin
				r.byte_kind = KIND_TLV_HDR;
				idx = {1'b0, hdr_idx[1:0]};
				case (idx[1:0])
					2'd0: cur_type = {8'h00, b};
					2'd1: cur_type[15:8] = b;
					2'd2: pay_left = {8'h00, b};
					default: pay_left[15:8] = b;
				endcase
				if (idx != 3'd3) begin
					hdr_idx = idx + 3'd1;
				end else if (33'd4 + {17'd0, pay_left} > pkt_left) begin
					r.frame_error = 1'b1;
					ph = PH_PKT;
					hdr_idx = 3'd0;
				end else begin
					pkt_left = pkt_left - 33'd4;
					if (pay_left == 16'd0) begin
						r.tlv_end = 1'b1;
						r.packet_end = end_of_tlv();
					end else begin
						ph = PH_PAY;
						hdr_idx = 3'd0;
					end
				end
			end
			PH_PAY: begin
				r.byte_kind = KIND_PAYLOAD;
				r.tlv_code = cur_type;
				r.to_handler = (cur_type == TYPE_IFRAME) || (cur_type == TYPE_PFRAME);
				if (pay_left != 16'd0) pay_left = pay_left - 16'd1;
				if (pkt_left != 33'd0) pkt_left = pkt_left - 33'd1;
				if (pay_left == 16'd0) begin
					r.tlv_end = 1'b1;
					r.packet_end = end_of_tlv();
				end
			end
			default: begin
				r.byte_kind = KIND_PKT_HDR;
				ph = PH_PKT;
				idx = hdr_idx;
				if (idx == 3'd0) begin
					pkt_left = {25'd0, b};
				end else if (idx < 3'd4) begin
					pkt_left = {1'b0, pkt_left[23:0], b};
				end else if (idx == 3'd4) begin
					seq = {24'd0, b};
				end else begin
					seq = seq | ({24'd0, b} << (8 * (idx - 3'd4)));
				end
				if (idx < 3'd7) begin
					hdr_idx = idx + 3'd1;
				end else begin
					hdr_idx = 3'd0;
					if (pkt_left <= 33'd4) begin
						r.frame_error = 1'b1;
						pkt_left = 33'd0;
					end else begin
						pkt_left = pkt_left - 33'd4;
						ph = PH_TLV;
					end
				end
			end
		endcase
		r.seq_no = seq;
		return r;
	endfunction

	task automatic drive_byte(input logic [7:0] b);
		int gap;
		gap = (idle_on && $urandom_range(0, 99) < 12) ? $urandom_range(1, 3) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		expected_tags.push_back(deframe_byte(b));
		drive_byte(b);
	endtask

	task automatic send_pkt_header(input logic [31:0] len, input logic [31:0] sq);
		send_byte(len[31:24]);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		send_byte(sq[7:0]);
		send_byte(sq[15:8]);
		send_byte(sq[23:16]);
		send_byte(sq[31:24]);
	endtask

	task automatic send_tlv_header(input logic [15:0] typ, input logic [15:0] len);
		send_byte(typ[7:0]);
		send_byte(typ[15:8]);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
	endtask

	task automatic send_good_packet();
		int n_tlv;
		int total;
		int i;
		int j;
		logic [15:0] types [4];
		logic [15:0] lens [4];
		n_tlv = $urandom_range(1, 4);
		total = 0;
		for (i = 0; i < n_tlv; i++) begin
			case ($urandom_range(0, 5))
				0: types[i] = TYPE_IFRAME;
				1: types[i] = TYPE_PFRAME;
				2: types[i] = 16'hFFFF;
				3: types[i] = {8'h00, 8'($urandom)};
				default: types[i] = 16'($urandom);
			endcase
			lens[i] = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 60))
				: 16'($urandom_range(0, 8));
			total += 4 + lens[i];
		end
		send_pkt_header(32'(total + 4), $urandom);
		for (i = 0; i < n_tlv; i++) begin
			send_tlv_header(types[i], lens[i]);
			for (j = 0; j < lens[i]; j++) send_byte(8'($urandom));
		end
	endtask

	// bring the parser back to the start of a packet header with few bytes
	task automatic resync_parser();
		logic [7:0] b;
		while (!(ph == PH_PKT && hdr_idx == 3'd0)) begin
			case (ph)
				PH_TLV: b = (hdr_idx[1:0] >= 2'd2) ? 8'hFF : 8'($urandom);
				PH_PAY: b = 8'($urandom);
				default: b = (hdr_idx < 3'd3) ? 8'h00 : 8'($urandom);
			endcase
			send_byte(b);
		end
	endtask

	task automatic report_mismatch(input string fname, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: %s got %0h expected %0h", $time, fname, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_tags.size() == 0) begin
				report_mismatch("unexpected transaction", 32'(m_axis_tdata[7:0]), 32'h0);
			end else begin
				want = expected_tags.pop_front();
				if (m_axis_tdata[7:0] !== want.byte_value)
					report_mismatch("byte_value", 32'(m_axis_tdata[7:0]), 32'(want.byte_value));
				if (m_axis_tuser[1:0] !== want.byte_kind)
					report_mismatch("byte_kind", 32'(m_axis_tuser[1:0]), 32'(want.byte_kind));
				if (m_axis_tdata[23:8] !== want.tlv_code)
					report_mismatch("tlv_code", 32'(m_axis_tdata[23:8]), 32'(want.tlv_code));
				if (m_axis_tuser[2] !== want.to_handler)
					report_mismatch("to_handler", 32'(m_axis_tuser[2]), 32'(want.to_handler));
				if (m_axis_tdata[24] !== want.tlv_end)
					report_mismatch("tlv_end", 32'(m_axis_tdata[24]), 32'(want.tlv_end));
				if (m_axis_tlast !== want.packet_end)
					report_mismatch("packet_end", 32'(m_axis_tlast), 32'(want.packet_end));
				if (m_axis_tdata[56:25] !== want.seq_no)
					report_mismatch("seq_no", m_axis_tdata[56:25], want.seq_no);
				if (m_axis_tuser[3] !== want.frame_error)
					report_mismatch("frame_error", 32'(m_axis_tuser[3]), 32'(want.frame_error));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// receiver side
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_axis_tready <= idle_on ? ($urandom_range(0, 99) >= 12) : 1'b1;
			end
		end
	end

	initial begin
		int i;
		int j;
		int k;
		int n;
		bit hold_done;
		result_t pred;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		hold_done = 1'b0;
		ph = PH_PKT;
		hdr_idx = 3'd0;
		pkt_left = 33'd0;
		seq = 32'd0;
		cur_type = 16'd0;
		pay_left = 16'd0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < DIR_COUNT; i++) begin
			pred = deframe_byte(DIR_ROWS[i].din);
			expected_tags.push_back(DIR_ROWS[i].typed ? DIR_ROWS[i].tag : pred);
			drive_byte(DIR_ROWS[i].din);
		end

		while (bytes_sent < DIR_COUNT + RANDOM_BYTES) begin
			idle_on = !(bytes_sent >= 500 && bytes_sent < 800);
			if (!hold_done && bytes_sent >= 900) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			n = $urandom_range(0, 99);
			if (n < 80) begin
				send_good_packet();
			end else if (n < 88) begin
				// short packet
				send_pkt_header(32'($urandom_range(0, 4)), $urandom);
			end else if (n < 94) begin
				// TLV overruns the packet
				k = $urandom_range(1, 12);
				send_pkt_header(32'(k + 4), $urandom);
				send_tlv_header(16'($urandom), 16'(k + $urandom_range(0, 200)));
			end else begin
				// garbage inside a small packet
				send_pkt_header(32'($urandom_range(5, 255)), $urandom);
				k = $urandom_range(0, 20);
				for (j = 0; j < k && ph != PH_PKT; j++) send_byte(8'($urandom));
			end
			resync_parser();
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (expected_tags.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
